FILE: sv/ttrr_pkg.sv
package ttrr_pkg;

  localparam int SPEED_WIDTH = 32;
  localparam int THRUST_W    = 32;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int MAG_W       = THRUST_W;
  localparam int PROD_W      = MAG_W + CFG_W;
  localparam int ROOT_W      = PROD_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int CALC_W      = (SPEED_WIDTH + 1 > ROOT_W + 2) ? SPEED_WIDTH + 1 : ROOT_W + 2;

  localparam logic signed [CALC_W-1:0] SPEED_LIMIT =
    ({{(CALC_W-1){1'b0}}, 1'b1} << (SPEED_WIDTH - 1)) - {{(CALC_W-1){1'b0}}, 1'b1};
  localparam logic [SPEED_WIDTH-1:0] SPEED_MOST_NEG = {1'b1, {(SPEED_WIDTH-1){1'b0}}};

  localparam logic signed [CFG_W-1:0] THRUST_LO_RST     = -32'sd2621440;
  localparam logic signed [CFG_W-1:0] THRUST_HI_RST     = 32'sd2621440;
  localparam logic        [CFG_W-1:0] SPEED_GAIN_RST    = 32'd65536;
  localparam logic signed [CFG_W-1:0] DEADBAND_LOW_RST  = 32'sd0;
  localparam logic signed [CFG_W-1:0] DEADBAND_HIGH_RST = 32'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRUST_LO     = 3'd0,
    REG_THRUST_HI     = 3'd1,
    REG_SPEED_GAIN    = 3'd2,
    REG_DEADBAND_LOW  = 3'd3,
    REG_DEADBAND_HIGH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] thrust_lo;
    logic signed [CFG_W-1:0] thrust_hi;
    logic        [CFG_W-1:0] speed_gain;
    logic signed [CFG_W-1:0] deadband_low;
    logic signed [CFG_W-1:0] deadband_high;
  } cfg_t;

  // One square root step in flight: radicand bits still to bring down,
  // partial remainder and partial root.
  typedef struct packed {
    logic              neg;
    logic [PROD_W-1:0] rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

endpackage

FILE: sv/ttrr_front.sv
module ttrr_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ttrr_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ttrr_pkg::THRUST_W-1:0] thrust_request,
  input  logic                                 request_valid,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ttrr_pkg::sq_t                        out_data
);

  logic                              mag_valid;
  logic                              mag_ready;
  logic [ttrr_pkg::MAG_W-1:0]        mag;
  logic                              mag_neg;
  logic signed [ttrr_pkg::THRUST_W-1:0] clamped;
  logic [ttrr_pkg::MAG_W-1:0]        mag_next;
  logic                              neg_next;

  always_comb begin
    if (thrust_request < cfg.thrust_lo) begin
      clamped = cfg.thrust_lo;
    end else if (thrust_request > cfg.thrust_hi) begin
      clamped = cfg.thrust_hi;
    end else begin
      clamped = thrust_request;
    end
    // drop a missing request to a zero magnitude, which yields speed 0
    if (!request_valid) begin
      mag_next = '0;
      neg_next = 1'b0;
    end else if (clamped < 0) begin
      mag_next = ttrr_pkg::MAG_W'(-clamped);
      neg_next = 1'b1;
    end else begin
      mag_next = ttrr_pkg::MAG_W'(clamped);
      neg_next = 1'b0;
    end
  end

  assign mag_ready = !out_valid || out_ready;
  assign in_ready  = !mag_valid || mag_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (in_ready) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag     <= mag_next;
      mag_neg <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mag_ready) begin
      out_valid <= mag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && mag_valid) begin
      out_data.neg  <= mag_neg;
      out_data.rad  <= ttrr_pkg::PROD_W'(mag) * ttrr_pkg::PROD_W'(cfg.speed_gain);
      out_data.rem  <= '0;
      out_data.root <= '0;
    end
  end

endmodule

FILE: sv/ttrr_cell.sv
module ttrr_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ttrr_pkg::sq_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ttrr_pkg::sq_t out_data
);

  logic [ttrr_pkg::REM_W-1:0] rem_sh;
  logic [ttrr_pkg::REM_W-1:0] trial;
  ttrr_pkg::sq_t              step;

  always_comb begin
    // bring down the next two radicand bits and try root*4+1
    rem_sh   = {in_data.rem[ttrr_pkg::REM_W-3:0], in_data.rad[ttrr_pkg::PROD_W-1 -: 2]};
    trial    = {1'b0, in_data.root, 2'b01};
    step.neg = in_data.neg;
    step.rad = {in_data.rad[ttrr_pkg::PROD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      step.rem  = rem_sh - trial;
      step.root = {in_data.root[ttrr_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      step.rem  = rem_sh;
      step.root = {in_data.root[ttrr_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= step;
    end
  end

endmodule

FILE: sv/ttrr_back.sv
module ttrr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  ttrr_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ttrr_pkg::sq_t                       in_data,
  output logic                                speed_valid,
  input  logic                                speed_stall,
  output logic [ttrr_pkg::SPEED_WIDTH-1:0]    speed_command
);

  logic signed [ttrr_pkg::CALC_W-1:0] root_ext;
  logic signed [ttrr_pkg::CALC_W-1:0] speed;
  logic signed [ttrr_pkg::CALC_W-1:0] db_low;
  logic signed [ttrr_pkg::CALC_W-1:0] db_high;
  logic signed [ttrr_pkg::CALC_W-1:0] gated;
  logic signed [ttrr_pkg::CALC_W-1:0] sat;

  always_comb begin
    root_ext = {{(ttrr_pkg::CALC_W-ttrr_pkg::ROOT_W){1'b0}}, in_data.root};
    speed    = in_data.neg ? -root_ext : root_ext;
    db_low   = {{(ttrr_pkg::CALC_W-ttrr_pkg::CFG_W){cfg.deadband_low[ttrr_pkg::CFG_W-1]}},
                cfg.deadband_low};
    db_high  = {{(ttrr_pkg::CALC_W-ttrr_pkg::CFG_W){cfg.deadband_high[ttrr_pkg::CFG_W-1]}},
                cfg.deadband_high};
    gated    = (speed > db_low && speed < db_high) ? '0 : speed;
    if (gated > ttrr_pkg::SPEED_LIMIT) begin
      sat = ttrr_pkg::SPEED_LIMIT;
    end else if (gated < -ttrr_pkg::SPEED_LIMIT) begin
      sat = -ttrr_pkg::SPEED_LIMIT;
    end else begin
      sat = gated;
    end
  end

  assign in_ready = !speed_valid || !speed_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_valid <= 1'b0;
    end else if (in_ready) begin
      speed_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      speed_command <= sat[ttrr_pkg::SPEED_WIDTH-1:0];
    end
  end

endmodule

FILE: sv/thrust_to_rotation_rate_core.sv
// Pipeline from an accepted request to its speed command: clamp, multiply,
// 32 square root cells, deadband and saturation register.
// Throughput: one request per cycle; each cell of the square root chain resolves one
// root bit and holds one request, and empty stages close up under output stall.
// Reset (synchronous, active high) empties every stage and loads the register defaults.
module thrust_to_rotation_rate_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ttrr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttrr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 thrust_valid,
  output logic                                 thrust_stall,
  input  logic signed [ttrr_pkg::THRUST_W-1:0] thrust_request,
  input  logic                                 request_valid,
  output logic                                 speed_valid,
  input  logic                                 speed_stall,
  output logic [ttrr_pkg::SPEED_WIDTH-1:0]     speed_command
);

  ttrr_pkg::cfg_t cfg;
  logic           front_ready;
  logic           cell_valid [0:ttrr_pkg::ROOT_W];
  logic           cell_ready [0:ttrr_pkg::ROOT_W];
  ttrr_pkg::sq_t  cell_data  [0:ttrr_pkg::ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thrust_lo     <= ttrr_pkg::THRUST_LO_RST;
      cfg.thrust_hi     <= ttrr_pkg::THRUST_HI_RST;
      cfg.speed_gain    <= ttrr_pkg::SPEED_GAIN_RST;
      cfg.deadband_low  <= ttrr_pkg::DEADBAND_LOW_RST;
      cfg.deadband_high <= ttrr_pkg::DEADBAND_HIGH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ttrr_pkg::REG_THRUST_LO:     cfg.thrust_lo     <= cfg_data;
        ttrr_pkg::REG_THRUST_HI:     cfg.thrust_hi     <= cfg_data;
        ttrr_pkg::REG_SPEED_GAIN:    cfg.speed_gain    <= cfg_data;
        ttrr_pkg::REG_DEADBAND_LOW:  cfg.deadband_low  <= cfg_data;
        ttrr_pkg::REG_DEADBAND_HIGH: cfg.deadband_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign thrust_stall = !front_ready;

  ttrr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (thrust_valid),
    .in_ready       (front_ready),
    .thrust_request (thrust_request),
    .request_valid  (request_valid),
    .out_valid      (cell_valid[0]),
    .out_ready      (cell_ready[0]),
    .out_data       (cell_data[0])
  );

  for (genvar i = 0; i < ttrr_pkg::ROOT_W; i++) begin : g_cell
    ttrr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_data   (cell_data[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_data  (cell_data[i+1])
    );
  end

  ttrr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (cell_valid[ttrr_pkg::ROOT_W]),
    .in_ready      (cell_ready[ttrr_pkg::ROOT_W]),
    .in_data       (cell_data[ttrr_pkg::ROOT_W]),
    .speed_valid   (speed_valid),
    .speed_stall   (speed_stall),
    .speed_command (speed_command)
  );

endmodule

FILE: sv/ttrr_check.sv
module ttrr_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             thrust_stall,
  input logic                             speed_valid,
  input logic                             speed_stall,
  input logic [ttrr_pkg::SPEED_WIDTH-1:0] speed_command
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    speed_valid && speed_stall |=> speed_valid && $stable(speed_command))
    else $error("stalled speed command changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !speed_valid)
    else $error("result valid right after reset");

  // saturation keeps the most negative code out
  a_no_most_neg: assert property (@(posedge clk) disable iff (rst)
    speed_valid |-> speed_command != ttrr_pkg::SPEED_MOST_NEG)
    else $error("speed command is the most negative code");

  // with the output register empty the chain has room for a request
  a_room: assert property (@(posedge clk) disable iff (rst)
    !speed_valid |-> !thrust_stall)
    else $error("request stalled while the output is empty");

  a_idle_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !speed_valid && !thrust_stall)
    else $error("pipeline not empty after reset");

endmodule

bind thrust_to_rotation_rate_core ttrr_check u_ttrr_check (
  .clk           (clk),
  .rst           (rst),
  .thrust_stall  (thrust_stall),
  .speed_valid   (speed_valid),
  .speed_stall   (speed_stall),
  .speed_command (speed_command)
);
